// ----- design/tms_pkg.sv -----
`default_nettype none

package tms_pkg;

   // Field widths
   localparam int TimeWidth   = 16;
   localparam int CoordWidth  = 32;
   localparam int MagWidth    = 32;
   localparam int RootWidth   = 34;
   localparam int PathWidth   = 40;
   localparam int SpeedWidth  = 32;
   localparam int AngleWidth  = 14;
   localparam int AzWidth     = 16;
   localparam int PolarWidth  = 15;

   // CORDIC setup
   localparam int CordicSteps = 20;
   localparam int CordicWidth = 45;
   localparam int NormWidth   = 41;
   localparam int ZWidth      = 25;
   localparam logic [22:0] Deg90Fine = 23'd5898240;
   localparam logic [15:0] Deg180Out = 16'd23040;

   localparam logic [SpeedWidth-1:0] SpeedMax = '1;
   localparam logic [PathWidth-1:0]  PathMax  = '1;

   // atan(2^-i) in 1/65536 degree
   function automatic logic [22:0] atan_fine(input logic [4:0] idx);
      logic [22:0] val;
      case (idx)
         5'd0:    val = 23'd2949120;
         5'd1:    val = 23'd1740967;
         5'd2:    val = 23'd919879;
         5'd3:    val = 23'd466945;
         5'd4:    val = 23'd234379;
         5'd5:    val = 23'd117304;
         5'd6:    val = 23'd58666;
         5'd7:    val = 23'd29335;
         5'd8:    val = 23'd14668;
         5'd9:    val = 23'd7334;
         5'd10:   val = 23'd3667;
         5'd11:   val = 23'd1833;
         5'd12:   val = 23'd917;
         5'd13:   val = 23'd458;
         5'd14:   val = 23'd229;
         5'd15:   val = 23'd115;
         5'd16:   val = 23'd57;
         5'd17:   val = 23'd29;
         5'd18:   val = 23'd14;
         5'd19:   val = 23'd7;
         default: val = 23'd0;
      endcase
      return val;
   endfunction

   // |a - b| of two signed coordinates
   function automatic logic [MagWidth-1:0] diff_mag(input logic [CoordWidth-1:0] a,
                                                   input logic [CoordWidth-1:0] b);
      logic [CoordWidth:0] d;
      logic [CoordWidth:0] n;
      d = {a[CoordWidth-1], a} - {b[CoordWidth-1], b};
      n = -d;
      return d[CoordWidth] ? n[MagWidth-1:0] : d[MagWidth-1:0];
   endfunction

   // sign of a - b
   function automatic logic diff_neg(input logic [CoordWidth-1:0] a,
                                     input logic [CoordWidth-1:0] b);
      logic [CoordWidth:0] d;
      d = {a[CoordWidth-1], a} - {b[CoordWidth-1], b};
      return d[CoordWidth];
   endfunction

endpackage

`default_nettype wire

// ----- design/tms_norm.sv -----
`default_nettype none

// floor(sqrt(a^2 + b^2 + c^2)): three squares on one multiplier, then a
// bit-pair restoring square root, one result bit per cycle
module tms_norm
   import tms_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [MagWidth-1:0]  a_in,
   input  wire logic [MagWidth-1:0]  b_in,
   input  wire logic [MagWidth-1:0]  c_in,
   output logic                      done,
   output logic [RootWidth-1:0]      root_out
);

   typedef enum logic [1:0] {N_IDLE, N_SQUARE, N_ROOT} norm_state_type;

   localparam int AccWidth = 2 * RootWidth;
   localparam int RemWidth = RootWidth + 3;

   norm_state_type state_ff, state_in;
   logic [MagWidth-1:0]  a_ff, a_in_r, b_ff, b_in_r, c_ff, c_in_r;
   logic [AccWidth-1:0]  acc_ff, acc_in;
   logic [RemWidth-1:0]  rem_ff, rem_in;
   logic [RootWidth-1:0] root_ff, root_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   logic [2*MagWidth-1:0] square;
   logic [RemWidth-1:0]   rem_sh, trial;

   assign square = a_ff * a_ff;
   assign rem_sh = {rem_ff[RemWidth-3:0], acc_ff[AccWidth-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      state_in = state_ff;
      a_in_r   = a_ff;
      b_in_r   = b_ff;
      c_in_r   = c_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         N_IDLE: begin
            if (start) begin
               a_in_r   = a_in;
               b_in_r   = b_in;
               c_in_r   = c_in;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = N_SQUARE;
            end
         end
         // accumulate one square a cycle, operands shift down
         N_SQUARE: begin
            acc_in = acc_ff + AccWidth'(square);
            a_in_r = b_ff;
            b_in_r = c_ff;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd2) begin
               cnt_in   = '0;
               rem_in   = '0;
               root_in  = '0;
               state_in = N_ROOT;
            end
         end
         // one root bit per cycle
         N_ROOT: begin
            acc_in = {acc_ff[AccWidth-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[RootWidth-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[RootWidth-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(RootWidth - 1)) begin
               done_in  = 1'b1;
               state_in = N_IDLE;
            end
         end
         default: state_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      a_ff    <= a_in_r;
      b_ff    <= b_in_r;
      c_ff    <= c_in_r;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done     = done_ff;
   assign root_out = root_ff;

endmodule

`default_nettype wire

// ----- design/tms_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle
module tms_div
   import tms_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [PathWidth-1:0]  dividend,
   input  wire logic [TimeWidth-1:0]  divisor,
   output logic                       done,
   output logic [PathWidth-1:0]       quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [PathWidth-1:0] q_ff, q_in;
   logic [TimeWidth-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [TimeWidth:0]   rem_sh;

   assign rem_sh = {rem_ff, q_ff[PathWidth-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            q_in    = dividend;
            rem_in  = '0;
            dsr_in  = divisor;
         end
      end else begin
         // dividend bits shift out the top, quotient bits in the bottom
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = TimeWidth'(rem_sh - {1'b0, dsr_ff});
            q_in   = {q_ff[PathWidth-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[TimeWidth-1:0];
            q_in   = {q_ff[PathWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(PathWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// ----- design/tms_cordic.sv -----
`default_nettype none

// vectoring CORDIC: angle of (ax, ay) in 1/128 degree, 0..90 degrees
module tms_cordic
   import tms_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [RootWidth-1:0]   ax_in,
   input  wire logic [RootWidth-1:0]   ay_in,
   output logic                        done,
   output logic [AngleWidth-1:0]       angle
);

   typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER, C_FIN} cordic_state_type;

   cordic_state_type state_ff, state_in;
   logic [NormWidth-1:0]          ax_ff, ax_in_r, ay_ff, ay_in_r;
   logic signed [CordicWidth-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZWidth-1:0]      z_ff, z_in;
   logic [4:0]                    i_ff, i_in;
   logic [AngleWidth-1:0]         res_ff, res_in;
   logic                          done_ff, done_in;

   logic [NormWidth-1:0]          mx;
   logic signed [CordicWidth-1:0] xs, ys;
   logic signed [ZWidth-1:0]      atan_s;
   logic [22:0]                   zc;
   logic [23:0]                   zr;

   // arithmetic right shift rounding toward zero
   function automatic logic signed [CordicWidth-1:0] shr_tz(
      input logic signed [CordicWidth-1:0] v, input logic [4:0] k);
      logic [CordicWidth-1:0] a;
      logic [CordicWidth-1:0] s;
      a = v[CordicWidth-1] ? -v : v;
      s = a >> k;
      return v[CordicWidth-1] ? -$signed(s) : $signed(s);
   endfunction

   assign mx     = (ax_ff > ay_ff) ? ax_ff : ay_ff;
   assign xs     = shr_tz(x_ff, i_ff);
   assign ys     = shr_tz(y_ff, i_ff);
   assign atan_s = $signed({2'b00, atan_fine(i_ff)});

   // clamp to 0..90 degrees, then round half up
   always_comb begin
      if (z_ff[ZWidth-1])
         zc = '0;
      else if (z_ff[22:0] > Deg90Fine || z_ff[ZWidth-2:23] != '0)
         zc = Deg90Fine;
      else
         zc = z_ff[22:0];
      zr = {1'b0, zc} + 24'd256;
   end

   always_comb begin
      state_in = state_ff;
      ax_in_r  = ax_ff;
      ay_in_r  = ay_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      i_in     = i_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               if (ax_in == '0 && ay_in == '0) begin
                  res_in  = '0;
                  done_in = 1'b1;
               end else begin
                  ax_in_r  = NormWidth'(ax_in);
                  ay_in_r  = NormWidth'(ay_in);
                  state_in = C_NORM;
               end
            end
         end
         // bring the larger magnitude into [2^40, 2^41)
         C_NORM: begin
            if (mx[NormWidth-1]) begin
               x_in     = $signed(CordicWidth'(ax_ff));
               y_in     = $signed(CordicWidth'(ay_ff));
               z_in     = '0;
               i_in     = '0;
               state_in = C_ITER;
            end else if (mx[NormWidth-1:33] == '0) begin
               ax_in_r = ax_ff << 8;
               ay_in_r = ay_ff << 8;
            end else begin
               ax_in_r = ax_ff << 1;
               ay_in_r = ay_ff << 1;
            end
         end
         // one micro-rotation per cycle
         C_ITER: begin
            if (y_ff > 0) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_s;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_s;
            end
            i_in = i_ff + 5'd1;
            if (i_ff == 5'(CordicSteps - 1))
               state_in = C_FIN;
         end
         C_FIN: begin
            res_in   = zr[9 +: AngleWidth];
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      ax_ff  <= ax_in_r;
      ay_ff  <= ay_in_r;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      i_ff   <= i_in;
      res_ff <= res_in;
   end

   assign done  = done_ff;
   assign angle = res_ff;

endmodule

`default_nettype wire

// ----- design/track_motion_statistics_top.sv -----
// Track motion statistics.
// Request channel (req_*): one track point per request, time strictly
// increasing within a track; req_last_point closes the track. req_stall is
// high while a point is being worked on, so one point is in flight at a time.
// Response channel (rsp_*): exactly one response per request, held in an
// output register; rsp_valid stays high and the fields stay put while
// rsp_stall is high. A new point may be accepted while a response waits.
// A first point or an out-of-order point goes straight to the response. A
// following point takes three squares on one multiplier, 34 square root
// steps and 40 divider steps. A closing point adds two more square roots
// (net distance, horizontal radius), the mean speed division and, if the
// track moved, two CORDIC angle runs (a normalize phase and 20 rotations
// each). The next request is taken in the cycle after the response is
// loaded.
// Reset: synchronous, active high; closes any open track, empties the
// response register. If the receiver stalls, the finished response waits in
// the block until the output register is free.
`default_nettype none

module track_motion_statistics_top
   import tms_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [TimeWidth-1:0]         req_time_point,
   input  wire logic signed [CoordWidth-1:0] req_x_coord,
   input  wire logic signed [CoordWidth-1:0] req_y_coord,
   input  wire logic signed [CoordWidth-1:0] req_z_coord,
   input  wire logic                         req_last_point,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [SpeedWidth-1:0]             rsp_segment_speed,
   output logic [PathWidth-1:0]              rsp_path_length_out,
   output logic [SpeedWidth-1:0]             rsp_peak_speed_out,
   output logic [SpeedWidth-1:0]             rsp_mean_speed,
   output logic [SpeedWidth-1:0]             rsp_net_distance,
   output logic signed [AzWidth-1:0]         rsp_azimuth,
   output logic [PolarWidth-1:0]             rsp_polar_angle,
   output logic                              rsp_final_res,
   output logic                              rsp_order_error
);

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_STEP, S_SPEED, S_NET, S_RHO, S_MEAN, S_THETA, S_PHI, S_OUT
   } top_state_type;

   top_state_type state_ff, state_in;

   // latched request
   logic [TimeWidth-1:0]  in_t_ff, in_t_in;
   logic [CoordWidth-1:0] in_x_ff, in_x_in, in_y_ff, in_y_in, in_z_ff, in_z_in;
   logic                  in_last_ff, in_last_in;

   // track state
   logic                  has_ff, has_in;
   logic [TimeWidth-1:0]  first_t_ff, first_t_in, prev_t_ff, prev_t_in;
   logic [CoordWidth-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [CoordWidth-1:0] first_z_ff, first_z_in;
   logic [CoordWidth-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [CoordWidth-1:0] prev_z_ff, prev_z_in;
   logic [PathWidth-1:0]  path_ff, path_in;
   logic [SpeedWidth-1:0] peak_ff, peak_in;

   // working results
   logic [SpeedWidth-1:0]     w_speed_ff, w_speed_in, w_net_ff, w_net_in;
   logic [SpeedWidth-1:0]     w_mean_ff, w_mean_in;
   logic signed [AzWidth-1:0] w_az_ff, w_az_in;
   logic [PolarWidth-1:0]     w_pol_ff, w_pol_in;
   logic                      w_final_ff, w_final_in, w_err_ff, w_err_in;

   // displacement from the first point
   logic                  dx_neg_ff, dx_neg_in, dy_neg_ff, dy_neg_in, dz_neg_ff, dz_neg_in;
   logic                  dnz_ff, dnz_in;
   logic [MagWidth-1:0]   mdx_ff, mdx_in, mdy_ff, mdy_in, mdz_ff, mdz_in;
   logic [RootWidth-1:0]  rho_ff, rho_in;

   // response register
   logic                      rv_ff, rv_in;
   logic [SpeedWidth-1:0]     r_speed_ff, r_speed_in, r_peak_ff, r_peak_in;
   logic [SpeedWidth-1:0]     r_mean_ff, r_mean_in, r_net_ff, r_net_in;
   logic [PathWidth-1:0]      r_path_ff, r_path_in;
   logic signed [AzWidth-1:0] r_az_ff, r_az_in;
   logic [PolarWidth-1:0]     r_pol_ff, r_pol_in;
   logic                      r_final_ff, r_final_in, r_err_ff, r_err_in;

   // shared units
   logic                  norm_start, norm_done;
   logic [MagWidth-1:0]   norm_a, norm_b, norm_c;
   logic [RootWidth-1:0]  norm_root;
   logic                  div_start, div_done;
   logic [PathWidth-1:0]  div_dvd, div_q;
   logic [TimeWidth-1:0]  div_dsr;
   logic                  cor_start, cor_done;
   logic [RootWidth-1:0]  cor_ax, cor_ay;
   logic [AngleWidth-1:0] cor_angle;

   logic [PathWidth:0]    path_sum;
   logic [SpeedWidth-1:0] q_sat;
   logic [TimeWidth-1:0]  span;
   logic [AzWidth-1:0]    th_flip;
   logic [PolarWidth-1:0] ph_flip;

   tms_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .start    (norm_start),
      .a_in     (norm_a),
      .b_in     (norm_b),
      .c_in     (norm_c),
      .done     (norm_done),
      .root_out (norm_root)
   );

   tms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_q)
   );

   tms_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .ax_in (cor_ax),
      .ay_in (cor_ay),
      .done  (cor_done),
      .angle (cor_angle)
   );

   assign path_sum = {1'b0, path_ff} + (PathWidth + 1)'(norm_root);
   assign q_sat    = (div_q[PathWidth-1:SpeedWidth] != '0) ? SpeedMax : div_q[SpeedWidth-1:0];
   assign span     = in_t_ff - first_t_ff;
   assign th_flip  = dx_neg_ff ? (Deg180Out - AzWidth'(cor_angle)) : AzWidth'(cor_angle);
   assign ph_flip  = dz_neg_ff ? PolarWidth'(Deg180Out - AzWidth'(cor_angle))
                               : PolarWidth'(cor_angle);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      in_t_in    = in_t_ff;
      in_x_in    = in_x_ff;
      in_y_in    = in_y_ff;
      in_z_in    = in_z_ff;
      in_last_in = in_last_ff;
      has_in     = has_ff;
      first_t_in = first_t_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      first_z_in = first_z_ff;
      prev_t_in  = prev_t_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      prev_z_in  = prev_z_ff;
      path_in    = path_ff;
      peak_in    = peak_ff;
      w_speed_in = w_speed_ff;
      w_net_in   = w_net_ff;
      w_mean_in  = w_mean_ff;
      w_az_in    = w_az_ff;
      w_pol_in   = w_pol_ff;
      w_final_in = w_final_ff;
      w_err_in   = w_err_ff;
      dx_neg_in  = dx_neg_ff;
      dy_neg_in  = dy_neg_ff;
      dz_neg_in  = dz_neg_ff;
      dnz_in     = dnz_ff;
      mdx_in     = mdx_ff;
      mdy_in     = mdy_ff;
      mdz_in     = mdz_ff;
      rho_in     = rho_ff;
      rv_in      = rv_ff && rsp_stall;
      r_speed_in = r_speed_ff;
      r_path_in  = r_path_ff;
      r_peak_in  = r_peak_ff;
      r_mean_in  = r_mean_ff;
      r_net_in   = r_net_ff;
      r_az_in    = r_az_ff;
      r_pol_in   = r_pol_ff;
      r_final_in = r_final_ff;
      r_err_in   = r_err_ff;
      norm_start = 1'b0;
      norm_a     = diff_mag(in_x_ff, prev_x_ff);
      norm_b     = diff_mag(in_y_ff, prev_y_ff);
      norm_c     = diff_mag(in_z_ff, prev_z_ff);
      div_start  = 1'b0;
      div_dvd    = PathWidth'(norm_root);
      div_dsr    = in_t_ff - prev_t_ff;
      cor_start  = 1'b0;
      cor_ax     = RootWidth'(mdx_ff);
      cor_ay     = RootWidth'(mdy_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               in_t_in    = req_time_point;
               in_x_in    = req_x_coord;
               in_y_in    = req_y_coord;
               in_z_in    = req_z_coord;
               in_last_in = req_last_point;
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            w_speed_in = '0;
            w_net_in   = '0;
            w_mean_in  = '0;
            w_az_in    = '0;
            w_pol_in   = '0;
            w_final_in = 1'b0;
            w_err_in   = 1'b0;
            if (has_ff && in_t_ff <= prev_t_ff) begin
               // out-of-order point: flagged, track unchanged
               w_err_in = 1'b1;
               state_in = S_OUT;
            end else if (!has_ff) begin
               // opens a track; closes it at once if marked last
               first_t_in = in_t_ff;
               first_x_in = in_x_ff;
               first_y_in = in_y_ff;
               first_z_in = in_z_ff;
               prev_t_in  = in_t_ff;
               prev_x_in  = in_x_ff;
               prev_y_in  = in_y_ff;
               prev_z_in  = in_z_ff;
               path_in    = '0;
               peak_in    = '0;
               has_in     = !in_last_ff;
               w_final_in = in_last_ff;
               state_in   = S_OUT;
            end else begin
               norm_start = 1'b1;
               state_in   = S_STEP;
            end
         end
         // step length done: accumulate path, divide by time gap
         S_STEP: begin
            if (norm_done) begin
               div_start = 1'b1;
               path_in   = path_sum[PathWidth] ? PathMax : path_sum[PathWidth-1:0];
               prev_t_in = in_t_ff;
               prev_x_in = in_x_ff;
               prev_y_in = in_y_ff;
               prev_z_in = in_z_ff;
               state_in  = S_SPEED;
            end
         end
         S_SPEED: begin
            if (div_done) begin
               w_speed_in = q_sat;
               if (q_sat > peak_ff)
                  peak_in = q_sat;
               if (in_last_ff) begin
                  norm_a     = diff_mag(in_x_ff, first_x_ff);
                  norm_b     = diff_mag(in_y_ff, first_y_ff);
                  norm_c     = diff_mag(in_z_ff, first_z_ff);
                  norm_start = 1'b1;
                  mdx_in     = norm_a;
                  mdy_in     = norm_b;
                  mdz_in     = norm_c;
                  dx_neg_in  = diff_neg(in_x_ff, first_x_ff);
                  dy_neg_in  = diff_neg(in_y_ff, first_y_ff);
                  dz_neg_in  = diff_neg(in_z_ff, first_z_ff);
                  dnz_in     = (norm_a | norm_b | norm_c) != '0;
                  state_in   = S_NET;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         // net distance done: horizontal radius next
         S_NET: begin
            if (norm_done) begin
               w_net_in   = (norm_root[RootWidth-1:SpeedWidth] != '0) ? SpeedMax
                                                           : norm_root[SpeedWidth-1:0];
               norm_a     = mdx_ff;
               norm_b     = mdy_ff;
               norm_c     = '0;
               norm_start = 1'b1;
               state_in   = S_RHO;
            end
         end
         S_RHO: begin
            if (norm_done) begin
               rho_in    = norm_root;
               div_dvd   = path_ff;
               div_dsr   = span;
               div_start = 1'b1;
               state_in  = S_MEAN;
            end
         end
         S_MEAN: begin
            if (div_done) begin
               w_mean_in = (span == '0) ? '0 : q_sat;
               if (dnz_ff) begin
                  cor_start = 1'b1;
                  state_in  = S_THETA;
               end else begin
                  w_final_in = 1'b1;
                  has_in     = 1'b0;
                  state_in   = S_OUT;
               end
            end
         end
         S_THETA: begin
            if (cor_done) begin
               w_az_in   = dy_neg_ff ? -$signed(th_flip) : $signed(th_flip);
               cor_ax    = RootWidth'(mdz_ff);
               cor_ay    = rho_ff;
               cor_start = 1'b1;
               state_in  = S_PHI;
            end
         end
         S_PHI: begin
            if (cor_done) begin
               w_pol_in   = ph_flip;
               w_final_in = 1'b1;
               has_in     = 1'b0;
               state_in   = S_OUT;
            end
         end
         // hand over to the response register once it is free
         S_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in      = 1'b1;
               r_speed_in = w_speed_ff;
               r_path_in  = w_final_ff ? path_ff : '0;
               r_peak_in  = w_final_ff ? peak_ff : '0;
               r_mean_in  = w_mean_ff;
               r_net_in   = w_net_ff;
               r_az_in    = w_az_ff;
               r_pol_in   = w_pol_ff;
               r_final_in = w_final_ff;
               r_err_in   = w_err_ff;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         has_ff     <= 1'b0;
         rv_ff      <= 1'b0;
         first_t_ff <= '0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         first_z_ff <= '0;
         prev_t_ff  <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         prev_z_ff  <= '0;
         path_ff    <= '0;
         peak_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         has_ff     <= has_in;
         rv_ff      <= rv_in;
         first_t_ff <= first_t_in;
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         first_z_ff <= first_z_in;
         prev_t_ff  <= prev_t_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         prev_z_ff  <= prev_z_in;
         path_ff    <= path_in;
         peak_ff    <= peak_in;
      end
      in_t_ff    <= in_t_in;
      in_x_ff    <= in_x_in;
      in_y_ff    <= in_y_in;
      in_z_ff    <= in_z_in;
      in_last_ff <= in_last_in;
      w_speed_ff <= w_speed_in;
      w_net_ff   <= w_net_in;
      w_mean_ff  <= w_mean_in;
      w_az_ff    <= w_az_in;
      w_pol_ff   <= w_pol_in;
      w_final_ff <= w_final_in;
      w_err_ff   <= w_err_in;
      dx_neg_ff  <= dx_neg_in;
      dy_neg_ff  <= dy_neg_in;
      dz_neg_ff  <= dz_neg_in;
      dnz_ff     <= dnz_in;
      mdx_ff     <= mdx_in;
      mdy_ff     <= mdy_in;
      mdz_ff     <= mdz_in;
      rho_ff     <= rho_in;
      r_speed_ff <= r_speed_in;
      r_path_ff  <= r_path_in;
      r_peak_ff  <= r_peak_in;
      r_mean_ff  <= r_mean_in;
      r_net_ff   <= r_net_in;
      r_az_ff    <= r_az_in;
      r_pol_ff   <= r_pol_in;
      r_final_ff <= r_final_in;
      r_err_ff   <= r_err_in;
   end

   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rv_ff;
   assign rsp_segment_speed   = r_speed_ff;
   assign rsp_path_length_out = r_path_ff;
   assign rsp_peak_speed_out  = r_peak_ff;
   assign rsp_mean_speed      = r_mean_ff;
   assign rsp_net_distance    = r_net_ff;
   assign rsp_azimuth         = r_az_ff;
   assign rsp_polar_angle     = r_pol_ff;
   assign rsp_final_res       = r_final_ff;
   assign rsp_order_error     = r_err_ff;

   // an out-of-order response never closes a track
   a_err_not_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_order_error && rsp_final_res))
      else $error("order error response marked final");

   // summary fields are zero unless the track closes
   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_final_res) |->
         (rsp_path_length_out == '0 && rsp_peak_speed_out == '0 && rsp_net_distance == '0))
      else $error("summary fields set on non-final response");

   // peak covers the closing segment
   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_res) |-> (rsp_peak_speed_out >= rsp_segment_speed))
      else $error("peak speed below segment speed");

   // the track closes with every final response
   a_close: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && w_final_ff) |-> !has_ff)
      else $error("track still open after final point");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb
   import tms_pkg::*;
();

   typedef struct {
      logic [15:0]        tp;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               last;
   } point_type;

   typedef struct {
      logic [31:0]        speed;
      logic [39:0]        path;
      logic [31:0]        peak;
      logic [31:0]        mean;
      logic [31:0]        net;
      logic signed [15:0] az;
      logic [14:0]        polar;
      logic               fin;
      logic               oerr;
   } stats_type;

   typedef struct {
      point_type pt;
      logic      known;
      stats_type res;
   } row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall, req_last_point;
   logic [15:0] req_time_point;
   logic signed [31:0] req_x_coord, req_y_coord, req_z_coord;
   logic rsp_valid, rsp_stall;
   logic [31:0] rsp_segment_speed, rsp_peak_speed_out, rsp_mean_speed, rsp_net_distance;
   logic [39:0] rsp_path_length_out;
   logic signed [15:0] rsp_azimuth;
   logic [14:0] rsp_polar_angle;
   logic rsp_final_res, rsp_order_error;

   always #5 clock = ~clock;

   track_motion_statistics_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_time_point(req_time_point), .req_x_coord(req_x_coord),
      .req_y_coord(req_y_coord), .req_z_coord(req_z_coord),
      .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_segment_speed(rsp_segment_speed), .rsp_path_length_out(rsp_path_length_out),
      .rsp_peak_speed_out(rsp_peak_speed_out), .rsp_mean_speed(rsp_mean_speed),
      .rsp_net_distance(rsp_net_distance), .rsp_azimuth(rsp_azimuth),
      .rsp_polar_angle(rsp_polar_angle), .rsp_final_res(rsp_final_res),
      .rsp_order_error(rsp_order_error)
   );

   // track state of the predictor
   logic            trk_open;
   logic [15:0]     trk_t0, trk_tp;
   longint          trk_x0, trk_y0, trk_z0, trk_xp, trk_yp, trk_zp;
   longint unsigned trk_path;
   logic [31:0]     trk_peak;

   stats_type expected_stats[$];
   row_type   pending_rows[$];   // directed rows not yet accepted, in order
   int        mismatches = 0;
   bit        no_idle = 0;

   function automatic longint unsigned abs_diff(longint a, longint b);
      longint d;
      d = a - b;
      return (d < 0) ? longint'(-d) : d;
   endfunction

   // floor of the Euclidean norm, exact sum of squares
   function automatic longint unsigned isqrt3(longint unsigned a, longint unsigned b,
                                              longint unsigned c);
      logic [67:0] s, r, t;
      s = 68'(a) * 68'(a) + 68'(b) * 68'(b) + 68'(c) * 68'(c);
      r = '0;
      for (int b2 = 33; b2 >= 0; b2--) begin
         t = r | (68'd1 << b2);
         if (t * t <= s) r = t;
      end
      return longint'(r[33:0]);
   endfunction

   function automatic longint shift_tz(longint v, int k);
      if (v >= 0) return v >>> k;
      return -((-v) >>> k);
   endfunction

   // first quadrant angle of (ax, ay) in 1/128 degree
   function automatic int cordic_angle(longint unsigned ax, longint unsigned ay);
      longint unsigned m;
      longint cx, cy, cz, xs, ys;
      m = (ax > ay) ? ax : ay;
      cz = 0;
      if (m == 0) return 0;
      while (m < (64'd1 << 40)) begin
         m = m << 1; ax = ax << 1; ay = ay << 1;
      end
      cx = ax;
      cy = ay;
      for (int i = 0; i < 20; i++) begin
         xs = shift_tz(cx, i);
         ys = shift_tz(cy, i);
         if (cy > 0) begin
            cx += ys; cy -= xs; cz += longint'(atan_fine(5'(i)));
         end else begin
            cx -= ys; cy += xs; cz -= longint'(atan_fine(5'(i)));
         end
      end
      if (cz < 0) cz = 0;
      if (cz > longint'(Deg90Fine)) cz = longint'(Deg90Fine);
      return int'((cz + 256) >>> 9);
   endfunction

   // one track point through the statistics, updates the track state
   function automatic stats_type track_step(point_type p);
      stats_type r;
      longint x, y, z, dx, dy, dz;
      longint unsigned len, spd, span, mn, net, rho;
      int th, ph;
      r = '{default: '0};
      x = p.x; y = p.y; z = p.z;
      spd = 0;
      if (trk_open && p.tp <= trk_tp) begin
         r.oerr = 1'b1;
         return r;
      end
      if (!trk_open) begin
         trk_open = 1'b1;
         trk_t0 = p.tp; trk_x0 = x; trk_y0 = y; trk_z0 = z;
         trk_path = 0; trk_peak = 0;
      end else begin
         len = isqrt3(abs_diff(x, trk_xp), abs_diff(y, trk_yp), abs_diff(z, trk_zp));
         spd = len / longint'(p.tp - trk_tp);
         if (spd > 64'hFFFF_FFFF) spd = 64'hFFFF_FFFF;
         trk_path += len;
         if (trk_path > 64'hFF_FFFF_FFFF) trk_path = 64'hFF_FFFF_FFFF;
         if (spd > trk_peak) trk_peak = spd[31:0];
      end
      trk_tp = p.tp; trk_xp = x; trk_yp = y; trk_zp = z;
      r.speed = spd[31:0];
      if (p.last) begin
         span = p.tp - trk_t0;
         dx = x - trk_x0; dy = y - trk_y0; dz = z - trk_z0;
         net = isqrt3(abs_diff(x, trk_x0), abs_diff(y, trk_y0), abs_diff(z, trk_z0));
         mn = 0; th = 0; ph = 0;
         if (span != 0) begin
            mn = trk_path / span;
            if (mn > 64'hFFFF_FFFF) mn = 64'hFFFF_FFFF;
         end
         if (dx != 0 || dy != 0 || dz != 0) begin
            rho = isqrt3(abs_diff(x, trk_x0), abs_diff(y, trk_y0), 0);
            th = cordic_angle(abs_diff(x, trk_x0), abs_diff(y, trk_y0));
            if (dx < 0) th = 23040 - th;
            if (dy < 0) th = -th;
            ph = cordic_angle(abs_diff(z, trk_z0), rho);
            if (dz < 0) ph = 23040 - ph;
         end
         r.path = trk_path[39:0];
         r.peak = trk_peak;
         r.mean = mn[31:0];
         r.net = (net > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : net[31:0];
         r.az = th[15:0];
         r.polar = ph[14:0];
         r.fin = 1'b1;
         trk_open = 1'b0;
      end
      return r;
   endfunction

   // accepted request: predict, or take the typed-in row result
   always @(posedge clock) begin
      stats_type pred;
      point_type p;
      if (reset) begin
         trk_open = 1'b0;
      end else if (req_valid && !req_stall) begin
         p.tp = req_time_point; p.x = req_x_coord; p.y = req_y_coord;
         p.z = req_z_coord; p.last = req_last_point;
         pred = track_step(p);
         if (pending_rows.size() > 0) begin
            if (pending_rows[0].known) pred = pending_rows[0].res;
            void'(pending_rows.pop_front());
         end
         expected_stats.push_back(pred);
      end
   end

   // response check against the oldest expectation
   always @(posedge clock) begin
      stats_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
         end else begin
            e = expected_stats.pop_front();
            if (rsp_segment_speed !== e.speed || rsp_path_length_out !== e.path ||
                rsp_peak_speed_out !== e.peak || rsp_mean_speed !== e.mean ||
                rsp_net_distance !== e.net || rsp_azimuth !== e.az ||
                rsp_polar_angle !== e.polar || rsp_final_res !== e.fin ||
                rsp_order_error !== e.oerr) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display({"mismatch at %0t: exp spd %h path %h peak %h mean %h",
                            " net %h az %h pol %h fin %b oe %b"},
                           $realtime, e.speed, e.path, e.peak, e.mean, e.net, e.az, e.polar,
                           e.fin, e.oerr);
                  $display({"                 got spd %h path %h peak %h mean %h",
                            " net %h az %h pol %h fin %b oe %b"},
                           rsp_segment_speed, rsp_path_length_out, rsp_peak_speed_out,
                           rsp_mean_speed, rsp_net_distance, rsp_azimuth, rsp_polar_angle,
                           rsp_final_res, rsp_order_error);
               end
            end
         end
      end
   end

   // receiver stall, drawn per response
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         n = no_idle ? 0 : $urandom_range(0, 4);
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_point(point_type p);
      int n;
      n = no_idle ? 0 : $urandom_range(0, 4);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_time_point <= p.tp;
      req_x_coord <= p.x;
      req_y_coord <= p.y;
      req_z_coord <= p.z;
      req_last_point <= p.last;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic point_type mk(int t, logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] z, bit l);
      point_type p;
      p.tp = t[15:0]; p.x = x; p.y = y; p.z = z; p.last = l;
      return p;
   endfunction

   function automatic logic signed [31:0] rnd_coord(bit wide, logic signed [31:0] base);
      if (wide) return $urandom;
      return base + $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
   endfunction

   // stimulus
   initial begin
      row_type dir[$];
      row_type rw;
      stats_type zero_res, oe_res, single_res;
      point_type p;
      int t, len, gap, sent;
      bit wide;
      logic signed [31:0] bx, by, bz;

      reset = 1'b1;
      req_valid = 1'b0;
      req_time_point = '0;
      req_x_coord = '0;
      req_y_coord = '0;
      req_z_coord = '0;
      req_last_point = 1'b0;

      zero_res = '{default: '0};
      oe_res = zero_res;
      oe_res.oerr = 1'b1;
      single_res = zero_res;
      single_res.fin = 1'b1;

      // single point track, then two extreme tracks, each with an out-of-order point
      dir.push_back('{mk(5, 0, 0, 0, 1), 1, single_res});
      dir.push_back('{mk(0, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0), 1, zero_res});
      dir.push_back('{mk(0, 1, 2, 3, 1), 1, oe_res});
      dir.push_back('{mk(65535, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1), 0,
                      zero_res});
      dir.push_back('{mk(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0), 1, zero_res});
      dir.push_back('{mk(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0), 0, zero_res});
      dir.push_back('{mk(1, 0, 0, 0, 1), 1, oe_res});
      dir.push_back('{mk(65535, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1), 0,
                      zero_res});
      // straight up, then straight down
      dir.push_back('{mk(10, 0, 0, 0, 0), 1, zero_res});
      dir.push_back('{mk(20, 0, 0, 32'sh0001_0000, 1), 0, zero_res});
      dir.push_back('{mk(1, 7, 7, 7, 0), 1, zero_res});
      dir.push_back('{mk(2, 7, 7, -32'sh0003_0000, 1), 0, zero_res});
      // back to start: no displacement
      dir.push_back('{mk(1, 0, 0, 0, 0), 1, zero_res});
      dir.push_back('{mk(2, 32'sh0001_0000, 0, 0, 0), 0, zero_res});
      dir.push_back('{mk(3, 0, 0, 0, 1), 0, zero_res});
      // negative dx and dy, then negative dx and dz
      dir.push_back('{mk(0, 0, 0, 0, 0), 1, zero_res});
      dir.push_back('{mk(3, -32'sh0005_0000, -32'sh0007_0000, 3, 1), 0, zero_res});
      dir.push_back('{mk(100, 0, 0, 0, 0), 1, zero_res});
      dir.push_back('{mk(101, -32'sh0002_0000, 32'sh0001_0000, -5, 1), 0, zero_res});

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (dir[i]) pending_rows.push_back(dir[i]);
      foreach (dir[i]) send_point(dir[i].pt);

      // random tracks: mostly well ordered, some out-of-order noise
      sent = 0;
      while (sent < 1000) begin
         no_idle = (sent >= 400 && sent < 500);
         t = $urandom_range(0, 60000);
         len = $urandom_range(1, 8);
         wide = ($urandom_range(0, 4) == 0);
         bx = $urandom; by = $urandom; bz = $urandom;
         for (int k = 0; k < len; k++) begin
            if (k > 0) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_point(mk($urandom_range(0, t), $urandom, $urandom, $urandom,
                                $urandom_range(0, 1)));
                  sent++;
               end
               gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5000)
                                                 : $urandom_range(1, 20);
               if (gap > 65535 - t) gap = 65535 - t;
               t += gap;
            end
            bx = rnd_coord(wide, bx);
            by = rnd_coord(wide, by);
            bz = rnd_coord(wide, bz);
            p = mk(t, bx, by, bz, (k == len - 1) || (t == 65535));
            send_point(p);
            sent++;
            if (p.last) break;
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (expected_stats.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_stats.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
